// ----- src/ksd_pkg.sv -----
// shared types, constants and translation tables of the scancode decoder
`timescale 1ns / 1ps
package ksd_pkg;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [7:0] IGNORE_FROM = 8'hD9;
	localparam logic [7:0] EXT_PREFIX  = 8'hE0;
	localparam logic [7:0] RELEASE_BIT = 8'h80;
	localparam logic [6:0] CODE_MASK   = 7'h7F;
	localparam logic [7:0] LED_CMD     = 8'hED;
	localparam logic [6:0] EXT_UNKNOWN = 7'h59;

	localparam logic [6:0] SC_LSHIFT = 7'h2A;
	localparam logic [6:0] SC_RSHIFT = 7'h36;
	localparam logic [7:0] SC_CAPS   = 8'h3A;
	localparam logic [7:0] SC_NUM    = 8'h45;
	localparam logic [7:0] SC_SCROLL = 8'h46;

	localparam int LB_SCROLL = 0;
	localparam int LB_NUM    = 1;
	localparam int LB_CAPS   = 2;

	localparam int FQ_DEPTH = 2;
	localparam int OQ_DEPTH = 4;

	typedef struct packed {
		op_t        op;
		logic       press;
		logic       release_key;
		logic [7:0] raw;
		logic [6:0] raw_code;
		logic [6:0] ext_code;
		logic [2:0] lock_hit;
		logic [6:0] query;
	} item_t;

	typedef struct packed {
		logic [15:0] key_word;
		logic        word_valid;
		logic        not_empty;
		logic        key_is_down;
		logic        led_update;
		logic [2:0]  led_bits;
	} result_t;

	localparam logic [7:0] ROM_PLAIN [0:127] = '{
		8'h00,8'h00,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,8'h2D,8'h3D,8'h00,8'h00,
		8'h71,8'h77,8'h65,8'h72,8'h74,8'h79,8'h75,8'h69,8'h6F,8'h70,8'h5B,8'h5D,8'h00,8'h00,8'h61,8'h73,
		8'h64,8'h66,8'h67,8'h68,8'h6A,8'h6B,8'h6C,8'h3B,8'h27,8'h60,8'h00,8'h5C,8'h7A,8'h78,8'h63,8'h76,
		8'h62,8'h6E,8'h6D,8'h2C,8'h2E,8'h2F,8'h00,8'h2A,8'h00,8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2D,8'h00,8'h00,8'h00,8'h2B,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h2F,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
	};

	localparam logic [7:0] ROM_SHIFT [0:127] = '{
		8'h00,8'h00,8'h21,8'h40,8'h23,8'h24,8'h25,8'h5E,8'h26,8'h2A,8'h28,8'h29,8'h5F,8'h2B,8'h00,8'h00,
		8'h51,8'h57,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,8'h4F,8'h50,8'h7B,8'h7D,8'h00,8'h00,8'h41,8'h53,
		8'h44,8'h46,8'h47,8'h48,8'h4A,8'h4B,8'h4C,8'h3A,8'h22,8'h7E,8'h00,8'h7C,8'h5A,8'h58,8'h43,8'h56,
		8'h42,8'h4E,8'h4D,8'h3C,8'h3E,8'h3F,8'h00,8'h2A,8'h00,8'h20,8'h2A,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2D,8'h00,8'h00,8'h00,8'h2B,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h2F,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
	};

	localparam logic [7:0] ROM_CAPS [0:127] = '{
		8'h00,8'h00,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,8'h2D,8'h3D,8'h00,8'h00,
		8'h51,8'h57,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,8'h4F,8'h50,8'h5B,8'h5D,8'h00,8'h00,8'h41,8'h53,
		8'h44,8'h46,8'h47,8'h48,8'h4A,8'h4B,8'h4C,8'h3B,8'h27,8'h60,8'h00,8'h5C,8'h5A,8'h58,8'h43,8'h56,
		8'h42,8'h4E,8'h4D,8'h2C,8'h2E,8'h2F,8'h00,8'h2A,8'h00,8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2D,8'h00,8'h00,8'h00,8'h2B,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h2F,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
	};

	localparam logic [7:0] ROM_NUM [0:127] = '{
		8'h00,8'h00,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,8'h2D,8'h3D,8'h00,8'h00,
		8'h71,8'h77,8'h65,8'h72,8'h74,8'h79,8'h75,8'h69,8'h6F,8'h70,8'h5B,8'h5D,8'h00,8'h00,8'h61,8'h73,
		8'h64,8'h66,8'h67,8'h68,8'h6A,8'h6B,8'h6C,8'h3B,8'h27,8'h60,8'h00,8'h5C,8'h7A,8'h78,8'h63,8'h76,
		8'h62,8'h6E,8'h6D,8'h2C,8'h2E,8'h2F,8'h00,8'h2A,8'h00,8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h37,8'h38,8'h39,8'h2D,8'h34,8'h35,8'h36,8'h2B,8'h31,
		8'h32,8'h33,8'h30,8'h2E,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h2F,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
	};

	// extended key remap for the byte after the prefix
	function automatic logic [6:0] ext_map(input logic [6:0] c);
		logic [6:0] r;
		case (c)
			7'h1C: r = 7'h60;
			7'h1D: r = 7'h61;
			7'h35: r = 7'h62;
			7'h38: r = 7'h63;
			7'h47: r = 7'h64;
			7'h48: r = 7'h65;
			7'h49: r = 7'h66;
			7'h4B: r = 7'h67;
			7'h4D: r = 7'h68;
			7'h4F: r = 7'h69;
			7'h50: r = 7'h6A;
			7'h51: r = 7'h6B;
			7'h52: r = 7'h6C;
			7'h53: r = 7'h6D;
			default: r = EXT_UNKNOWN;
		endcase
		return r;
	endfunction

endpackage

// ----- src/ksd_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ksd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- src/ksd_front.sv -----
// front end: classifies incoming items and buffers them for the back end
`timescale 1ns / 1ps
module ksd_front import ksd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] op,
	input  logic [7:0] scan_byte,
	input  logic [6:0] query_index,
	output item_t      item,
	output logic       item_valid,
	input  logic       item_take
);
	item_t      cls;
	item_t      slot_q [FQ_DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       wr_en, rd_en;
	logic       live;

	always_comb begin
		live              = (scan_byte < IGNORE_FROM);
		cls.op            = op_t'(op);
		cls.press         = live && ((scan_byte & RELEASE_BIT) == 8'h00);
		cls.release_key   = live && ((scan_byte & RELEASE_BIT) != 8'h00);
		cls.raw           = scan_byte;
		cls.raw_code      = scan_byte[6:0] & CODE_MASK;
		cls.ext_code      = ext_map(scan_byte[6:0]);
		cls.lock_hit[LB_SCROLL] = cls.press && (scan_byte == SC_SCROLL);
		cls.lock_hit[LB_NUM]    = cls.press && (scan_byte == SC_NUM);
		cls.lock_hit[LB_CAPS]   = cls.press && (scan_byte == SC_CAPS);
		cls.query         = query_index;
	end

	assign full       = (cnt_q == 2'(FQ_DEPTH));
	assign wr_en      = push && !full;
	assign item_valid = (cnt_q != 2'd0);
	assign rd_en      = item_take && item_valid;
	assign item       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end
endmodule

// ----- src/ksd_back.sv -----
// back end: key state, word buffer, translation and result queue
`timescale 1ns / 1ps
module ksd_back import ksd_pkg::*; #(
	parameter int FIFO_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        item_valid,
	output logic        item_take,
	input  logic        pop,
	output logic        empty,
	output logic [15:0] key_word,
	output logic        word_valid,
	output logic        not_empty,
	output logic        key_is_down,
	output logic        led_update,
	output logic [2:0]  led_bits
);
	localparam int PW = $clog2(FIFO_DEPTH);
	typedef logic [PW-1:0] ptr_t;

	logic [127:0] map_q, map_n;
	ptr_t         head_q, head_n, tail_q, tail_n;
	logic [7:0]   prev_q, prev_n;
	logic [2:0]   lock_q, lock_n;
	logic [6:0]   code;
	logic [7:0]   ascii;
	logic         shift_dn, push_word, led;
	logic [15:0]  rdata;

	result_t      res_s2;
	logic         valid_s2;
	result_t      oq_q [OQ_DEPTH];
	logic [1:0]   oq_wr_q, oq_rd_q;
	logic [2:0]   oq_cnt_q;
	logic [3:0]   committed;
	logic         oq_rd;
	result_t      res_now;
	result_t      oq_in;

	function automatic ptr_t inc(input ptr_t p);
		return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// count results already owed to the queue so a new item never overflows it
	assign committed = {1'b0, oq_cnt_q} + {3'b0, valid_s2};
	assign item_take = item_valid && (committed < 4'(OQ_DEPTH));

	always_comb begin
		map_n     = map_q;
		head_n    = head_q;
		tail_n    = tail_q;
		prev_n    = prev_q;
		lock_n    = lock_q;
		push_word = 1'b0;
		led       = 1'b0;
		res_now   = '0;
		code      = (prev_q == EXT_PREFIX) ? item.ext_code : item.raw_code;
		case (item.op)
			OP_BYTE: begin
				prev_n = item.raw;
				if (item.press) begin
					// typematic repeat of a lock key does not toggle
					if (prev_q != item.raw) begin
						lock_n = lock_q ^ item.lock_hit;
						led    = |item.lock_hit;
					end
					map_n[code] = 1'b1;
					prev_n      = {1'b0, code};
					push_word   = 1'b1;
					head_n      = inc(head_q);
					if (inc(head_q) == tail_q) begin
						tail_n = inc(tail_q);
					end
				end else if (item.release_key) begin
					map_n[code] = 1'b0;
				end
			end
			OP_POP: begin
				if (head_q != tail_q) begin
					res_now.word_valid = 1'b1;
					tail_n             = inc(tail_q);
				end
			end
			OP_CLEAR: begin
				map_n  = '0;
				head_n = '0;
				tail_n = '0;
				prev_n = 8'h00;
			end
			default: begin
			end
		endcase
		shift_dn = map_n[SC_LSHIFT] || map_n[SC_RSHIFT];
		if (shift_dn) ascii = ROM_SHIFT[code];
		else if (lock_n[LB_NUM]) ascii = ROM_NUM[code];
		else if (lock_n[LB_CAPS]) ascii = ROM_CAPS[code];
		else ascii = ROM_PLAIN[code];
		res_now.not_empty   = (head_n != tail_n);
		res_now.key_is_down = map_n[item.query];
		res_now.led_update  = led;
		res_now.led_bits    = lock_n;
	end

	ksd_ram #(.WIDTH(16), .DEPTH(FIFO_DEPTH)) u_word_ram (
		.clk   (clk),
		.we    (item_take && push_word),
		.waddr (head_q),
		.wdata ({1'b0, code, ascii}),
		.raddr (tail_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			prev_q   <= 8'h00;
			lock_q   <= 3'b000;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= item_take;
			if (item_take) begin
				map_q  <= map_n;
				head_q <= head_n;
				tail_q <= tail_n;
				prev_q <= prev_n;
				lock_q <= lock_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			res_s2 <= res_now;
		end
	end

	// result queue, word read from ram joins in the cycle after execute
	assign empty = (oq_cnt_q == 3'd0);
	assign oq_rd = pop && !empty;

	always_comb begin
		oq_in          = res_s2;
		oq_in.key_word = res_s2.word_valid ? rdata : 16'h0000;
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			oq_q[oq_wr_q] <= oq_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 2'd0;
			oq_rd_q  <= 2'd0;
			oq_cnt_q <= 3'd0;
		end else begin
			if (valid_s2) oq_wr_q <= oq_wr_q + 2'd1;
			if (oq_rd) oq_rd_q <= oq_rd_q + 2'd1;
			oq_cnt_q <= oq_cnt_q + 3'(valid_s2) - 3'(oq_rd);
		end
	end

	assign key_word    = oq_q[oq_rd_q].key_word;
	assign word_valid  = oq_q[oq_rd_q].word_valid;
	assign not_empty   = oq_q[oq_rd_q].not_empty;
	assign key_is_down = oq_q[oq_rd_q].key_is_down;
	assign led_update  = oq_q[oq_rd_q].led_update;
	assign led_bits    = oq_q[oq_rd_q].led_bits;
endmodule

// ----- src/keyboard_scancode_decoder.sv -----
// top level of the scan code set 1 keyboard decoder
// a transfer in is held in the front buffer, executed into the stage register, then written to the result queue
// throughput: one item per cycle while the result queue has room, set by the state update in the back end
// the word buffer ram has registered read, the popped word joins the result in the cycle after execute
// reset: arst_n clears key map, pointers, last byte, lock bits and both queues
// buffer contents are not cleared and are never read before being written
`timescale 1ns / 1ps
module keyboard_scancode_decoder import ksd_pkg::*; #(
	parameter int FIFO_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  op,
	input  logic [7:0]  scan_byte,
	input  logic [6:0]  query_index,
	input  logic        pop,
	output logic        empty,
	output logic [15:0] key_word,
	output logic        word_valid,
	output logic        not_empty,
	output logic        key_is_down,
	output logic        led_update,
	output logic [2:0]  led_bits
);
	item_t item;
	logic  item_valid, item_take;

	ksd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.scan_byte   (scan_byte),
		.query_index (query_index),
		.item        (item),
		.item_valid  (item_valid),
		.item_take   (item_take)
	);

	ksd_back #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.item_valid  (item_valid),
		.item_take   (item_take),
		.pop         (pop),
		.empty       (empty),
		.key_word    (key_word),
		.word_valid  (word_valid),
		.not_empty   (not_empty),
		.key_is_down (key_is_down),
		.led_update  (led_update),
		.led_bits    (led_bits)
	);

	a_take_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |-> item_valid) else $error("back end took an item that was not there");

	a_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !word_valid) |-> (key_word == 16'h0000))
		else $error("key word nonzero without a popped word");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty) else $error("pending result vanished");
endmodule

// ----- sim/keyboard_scancode_decoder_test.sv -----
// self-checking testbench of the scan code set 1 keyboard decoder
`timescale 1ns / 1ps
module keyboard_scancode_decoder_test;
	import ksd_pkg::*;

	localparam int DEPTH = 128;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 60;

	typedef struct packed {
		logic [15:0] key_word;
		logic        word_valid;
		logic        not_empty;
		logic        key_is_down;
		logic        led_update;
		logic [2:0]  led_bits;
	} status_t;

	class key_scoreboard;
		logic        down_map [0:127];
		logic [15:0] words [0:DEPTH-1];
		int unsigned head, tail;
		logic [7:0]  last_byte;
		logic [2:0]  locks;
		status_t     pending [$];
		int          errors;

		function void clear_all();
			for (int i = 0; i < 128; i++) down_map[i] = 1'b0;
			for (int i = 0; i < DEPTH; i++) words[i] = '0;
			head = 0; tail = 0; last_byte = '0; locks = '0;
		endfunction

		function logic [6:0] remap(input logic [6:0] c);
			logic [6:0] r;
			case (c)
				7'h1C: r = 7'h60; 7'h1D: r = 7'h61; 7'h35: r = 7'h62; 7'h38: r = 7'h63;
				7'h47: r = 7'h64; 7'h48: r = 7'h65; 7'h49: r = 7'h66; 7'h4B: r = 7'h67;
				7'h4D: r = 7'h68; 7'h4F: r = 7'h69; 7'h50: r = 7'h6A; 7'h51: r = 7'h6B;
				7'h52: r = 7'h6C; 7'h53: r = 7'h6D;
				default: r = 7'h59;
			endcase
			return r;
		endfunction

		// note an accepted input and queue the status it must produce
		function void note_input(input op_t o, input logic [7:0] b, input logic [6:0] q);
			status_t s;
			logic [7:0] code;
			logic [6:0] k;
			logic [7:0] ch;
			s = '0;
			if (o == OP_BYTE) begin
				code = b;
				if (b < IGNORE_FROM) begin
					if (!b[7]) begin
						if (b == SC_CAPS && last_byte != SC_CAPS) begin
							locks[LB_CAPS] ^= 1'b1; s.led_update = 1'b1;
						end
						if (b == SC_NUM && last_byte != SC_NUM) begin
							locks[LB_NUM] ^= 1'b1; s.led_update = 1'b1;
						end
						if (b == SC_SCROLL && last_byte != SC_SCROLL) begin
							locks[LB_SCROLL] ^= 1'b1; s.led_update = 1'b1;
						end
						if (last_byte == EXT_PREFIX) code = {1'b0, remap(b[6:0])};
						code[7] = 1'b0;
						k = code[6:0];
						down_map[k] = 1'b1;
						if (down_map[SC_LSHIFT] || down_map[SC_RSHIFT]) ch = ROM_SHIFT[k];
						else if (locks[LB_NUM]) ch = ROM_NUM[k];
						else if (locks[LB_CAPS]) ch = ROM_CAPS[k];
						else ch = ROM_PLAIN[k];
						words[head] = {1'b0, k, ch};
						head = (head + 1) % DEPTH;
						// buffer full: oldest word is dropped
						if (head == tail) tail = (tail + 1) % DEPTH;
					end else begin
						k = (last_byte == EXT_PREFIX) ? remap(b[6:0]) : b[6:0];
						down_map[k] = 1'b0;
					end
				end
				last_byte = code;
			end else if (o == OP_POP) begin
				if (head != tail) begin
					s.key_word = words[tail];
					s.word_valid = 1'b1;
					tail = (tail + 1) % DEPTH;
				end
			end else if (o == OP_CLEAR) begin
				for (int i = 0; i < 128; i++) down_map[i] = 1'b0;
				head = 0; tail = 0; last_byte = '0;
			end
			s.not_empty = (head != tail);
			s.key_is_down = down_map[q];
			s.led_bits = locks;
			pending.push_back(s);
		endfunction

		task check_result(input status_t got);
			status_t want;
			if (pending.size() == 0) begin
				report_mismatch("result with nothing expected", 0, 0);
				return;
			end
			want = pending.pop_front();
			if (got.key_word !== want.key_word)
				report_mismatch("key_word", got.key_word, want.key_word);
			if (got.word_valid !== want.word_valid)
				report_mismatch("word_valid", got.word_valid, want.word_valid);
			if (got.not_empty !== want.not_empty)
				report_mismatch("not_empty", got.not_empty, want.not_empty);
			if (got.key_is_down !== want.key_is_down)
				report_mismatch("key_is_down", got.key_is_down, want.key_is_down);
			if (got.led_update !== want.led_update)
				report_mismatch("led_update", got.led_update, want.led_update);
			if (got.led_bits !== want.led_bits)
				report_mismatch("led_bits", got.led_bits, want.led_bits);
		endtask

		task report_mismatch(input string what, input int got, input int want);
			errors++;
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  op = OP_NONE;
	logic [7:0]  scan_byte = '0;
	logic [6:0]  query_index = '0;
	logic        pop = 1'b0;
	logic        empty;
	logic [15:0] key_word;
	logic        word_valid;
	logic        not_empty;
	logic        key_is_down;
	logic        led_update;
	logic [2:0]  led_bits;

	key_scoreboard sb;
	int  cycles = 0;
	int  hold_off = 0;
	int  hold_req = 0;
	int  hold_seen = 0;
	bit  quiet = 1'b0;
	logic [6:0] held_keys [$];

	keyboard_scancode_decoder dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_result({key_word, word_valid, not_empty, key_is_down,
					led_update, led_bits});
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_off <= HOLD_CYCLES;
				pop <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				pop <= 1'b0;
			end else begin
				pop <= quiet ? 1'b1 : ($urandom_range(99) >= 34);
			end
		end
	end

	// one transfer into the block, with a random gap before it unless quiet is set
	task automatic send(input op_t o, input logic [7:0] b, input logic [6:0] q);
		if (!quiet)
			while ($urandom_range(99) < 34) begin
				push <= 1'b0;
				@(posedge clk);
			end
		push <= 1'b1;
		op <= o;
		scan_byte <= b;
		query_index <= q;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_input(o, b, q);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// mostly well-formed key activity: presses, releases, prefixes, locks, pops, with random bytes, clears and no-ops
	task automatic send_random();
		int r;
		logic [7:0] b;
		logic [6:0] q;
		r = $urandom_range(99);
		q = (held_keys.size() != 0 && $urandom_range(1)) ?
			held_keys[$urandom_range(held_keys.size() - 1)] : 7'($urandom);
		if (r < 30) begin
			b = 8'($urandom_range(8'h58));
			held_keys.push_back(b[6:0]);
			if (held_keys.size() > 16) void'(held_keys.pop_front());
			send(OP_BYTE, b, q);
		end else if (r < 42) begin
			b = (held_keys.size() != 0) ? {1'b1, held_keys[$urandom_range(held_keys.size() - 1)]}
				: 8'($urandom_range(8'h80, 8'hD8));
			send(OP_BYTE, b, q);
		end else if (r < 52) begin
			send(OP_BYTE, EXT_PREFIX, q);
			b = 8'($urandom);
			if ($urandom_range(3) == 0) b = {$urandom_range(1) == 1 ? 1'b1 : 1'b0, 7'h1C};
			send(OP_BYTE, b, q);
		end else if (r < 58) begin
			case ($urandom_range(2))
				0: b = SC_CAPS;
				1: b = SC_NUM;
				default: b = SC_SCROLL;
			endcase
			send(OP_BYTE, b, q);
			if ($urandom_range(2) == 0) send(OP_BYTE, b, q);
		end else if (r < 64) begin
			send(OP_BYTE, 8'({SC_LSHIFT[6:0]} | ($urandom_range(1) ? 8'h80 : 8'h00)), q);
		end else if (r < 68) begin
			send(OP_BYTE, 8'($urandom), q);
		end else if (r < 92) begin
			send(OP_POP, 8'($urandom), q);
		end else if (r < 94) begin
			send(OP_CLEAR, 8'($urandom), q);
		end else begin
			send(OP_NONE, 8'($urandom), q);
		end
	endtask

	initial begin
		sb = new();
		sb.clear_all();
		sb.errors = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		send(OP_POP, 8'h00, 7'h00);
		send(OP_BYTE, 8'h00, 7'h00);
		send(OP_BYTE, 8'h1E, 7'h1E);
		send(OP_BYTE, SC_CAPS, 7'h3A);
		send(OP_BYTE, SC_CAPS, 7'h3A);
		send(OP_BYTE, 8'h1E, 7'h7F);
		send(OP_BYTE, SC_NUM, 7'h45);
		send(OP_BYTE, 8'h47, 7'h47);
		send(OP_BYTE, 8'h2A, 7'h2A);
		send(OP_BYTE, 8'h02, 7'h02);
		send(OP_BYTE, 8'hAA, 7'h2A);
		send(OP_BYTE, EXT_PREFIX, 7'h00);
		send(OP_BYTE, 8'h48, 7'h65);
		send(OP_BYTE, EXT_PREFIX, 7'h00);
		send(OP_BYTE, SC_SCROLL, 7'h59);
		send(OP_BYTE, EXT_PREFIX, 7'h00);
		send(OP_BYTE, 8'hC8, 7'h65);
		send(OP_BYTE, 8'hD8, 7'h58);
		send(OP_BYTE, 8'hD9, 7'h00);
		send(OP_BYTE, 8'hFF, 7'h7F);
		send(OP_NONE, 8'hFF, 7'h7F);
		send(OP_POP, 8'h00, 7'h1E);
		send(OP_CLEAR, 8'h00, 7'h1E);
		send(OP_POP, 8'h00, 7'h1E);
		drain();

		// overfill the word buffer so the oldest entries get dropped
		for (int i = 0; i < DEPTH + 10; i++) send(OP_BYTE, 8'($urandom_range(8'h58)), 7'($urandom));
		for (int i = 0; i < DEPTH + 2; i++) send(OP_POP, 8'h00, 7'($urandom));

		// long receiver hold-off while items keep coming
		hold_req = hold_req + 1;
		for (int i = 0; i < 40; i++) send_random();
		drain();

		for (int i = 0; i < 1200; i++) begin
			quiet = (i >= 500 && i < 700);
			send_random();
			if (i == 900) drain();
		end
		quiet = 1'b0;
		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ----- files.f -----
src/ksd_pkg.sv
src/ksd_ram.sv
src/ksd_front.sv
src/ksd_back.sv
src/keyboard_scancode_decoder.sv
sim/keyboard_scancode_decoder_test.sv
